### sv/rpm_pkg.sv
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared constants for the Rayleigh phase matrix core.
// ----------------------------------------------------------------------------
package rpm_pkg;

	// number of non-zero Mueller entries produced per transaction
	localparam int N_OUT = 10;

	// 3*pi/8 in Q1.24, rounded
	localparam int GAIN_W = 25;
	localparam logic [GAIN_W-1:0] GAIN_Q24 = 25'd19765192;

	// opacity register: reset value 1.0 in Q16.16, register index
	localparam logic [31:0] OPAC_RESET  = 32'h0001_0000;
	localparam logic [0:0]  REG_OPACITY = 1'b0;

	// entries that carry the extra factor of one half (I-I, I-Q, Q-I, Q-Q)
	localparam logic [N_OUT-1:0] HALF_ENTRY = 10'b00_0001_1011;

endpackage

### sv/rayleigh_phase_matrix_core.sv
// ----------------------------------------------------------------------------
// rayleigh_phase_matrix_core
// Rayleigh scattering Mueller matrix (ten non-zero entries) from an incoming
// and an outgoing direction, scaled by 3*pi/8 times the scattering opacity.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  config   | APB write/read      | paddr[2] = register index, pwdata/prdata
//  input    | start & !busy       | in_dir_x/y/z, out_dir_x/y/z (Q1.F)
//  result   | done, one cycle     | row0_col0 .. row3_col3 (Q15.16, saturated)
//
//  One transaction enters per clock; busy never rises.
//  The axis generators hold bit-per-stage square root and divide chains.
//  Reset clears the valid chain and loads the opacity with 1.0.
//  The receiver cannot stall: each result shows for one cycle with done.
// ----------------------------------------------------------------------------
module rayleigh_phase_matrix_core
	import rpm_pkg::*;
#(
	parameter int DIR_WIDTH = 16,
	parameter int OUT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [DIR_WIDTH-1:0] in_dir_x,
	input  logic signed [DIR_WIDTH-1:0] in_dir_y,
	input  logic signed [DIR_WIDTH-1:0] in_dir_z,
	input  logic signed [DIR_WIDTH-1:0] out_dir_x,
	input  logic signed [DIR_WIDTH-1:0] out_dir_y,
	input  logic signed [DIR_WIDTH-1:0] out_dir_z,
	output logic                        done,
	output logic signed [OUT_WIDTH-1:0] row0_col0,
	output logic signed [OUT_WIDTH-1:0] row0_col1,
	output logic signed [OUT_WIDTH-1:0] row0_col2,
	output logic signed [OUT_WIDTH-1:0] row1_col0,
	output logic signed [OUT_WIDTH-1:0] row1_col1,
	output logic signed [OUT_WIDTH-1:0] row1_col2,
	output logic signed [OUT_WIDTH-1:0] row2_col0,
	output logic signed [OUT_WIDTH-1:0] row2_col1,
	output logic signed [OUT_WIDTH-1:0] row2_col2,
	output logic signed [OUT_WIDTH-1:0] row3_col3
);

	localparam int DW      = DIR_WIDTH;
	localparam int F       = DW - 2;
	localparam int LATENCY = 2*DW + 12;
	localparam int DTW     = 2*DW + 2;        // dot product sums
	localparam int SW      = DW + 2;          // S11..S22
	localparam int CW      = 2*SW + 3;        // entry sums before rounding
	localparam int MW      = DW + 3;          // rounded entry magnitude
	localparam int PW      = MW + 32;         // magnitude * opacity
	localparam int QW      = PW + 1 - F;      // back in Q.16
	localparam int GW      = QW + GAIN_W;     // times 3*pi/8 in Q.24
	localparam int UW      = GW + 1 - 24;
	localparam int SATW    = ((UW > OUT_WIDTH) ? UW : OUT_WIDTH) + 1;

	localparam logic signed [DTW-1:0] HF_D  = DTW'(1) << (F-1);
	localparam logic [PW:0]           H_OP  = (PW+1)'(1) << (F-1);
	localparam logic [GW:0]           H_GN  = (GW+1)'(1) << 23;
	localparam logic [SATW-1:0]       LIM_N = SATW'(1) << (OUT_WIDTH-1);
	localparam logic [SATW-1:0]       MAX_P = LIM_N - SATW'(1);

	// ---------------- configuration ----------------
	logic [31:0] opac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opac_q <= OPAC_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_OPACITY) begin
			opac_q <= pwdata;
		end
	end

	assign prdata = (paddr[2:2] == REG_OPACITY) ? opac_q : '0;
	assign pready = 1'b1;
	assign busy   = 1'b0;

	// ---------------- axis generators ----------------
	logic                 va, vb;
	logic signed [DW-1:0] t1x, t1y, t1z, p1x, p1y;
	logic signed [DW-1:0] t2x, t2y, t2z, p2x, p2y;

	rpm_axes #(.DW(DW)) u_axes_in (
		.clk, .arst_n, .in_vld(start),
		.dir_x(in_dir_x), .dir_y(in_dir_y), .dir_z(in_dir_z),
		.out_vld(va), .t_x(t1x), .t_y(t1y), .t_z(t1z), .p_x(p1x), .p_y(p1y)
	);

	rpm_axes #(.DW(DW)) u_axes_out (
		.clk, .arst_n, .in_vld(start),
		.dir_x(out_dir_x), .dir_y(out_dir_y), .dir_z(out_dir_z),
		.out_vld(vb), .t_x(t2x), .t_y(t2y), .t_z(t2z), .p_x(p2x), .p_y(p2y)
	);

	// ---------------- valid chain ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else begin
			v_s1 <= va & vb;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign done = v_s9;

	// s1: axis component products
	logic signed [2*DW-1:0] pr_s1 [9];

	always_ff @(posedge clk) begin
		pr_s1[0] <= t1x * t2x;
		pr_s1[1] <= t1y * t2y;
		pr_s1[2] <= t1z * t2z;
		pr_s1[3] <= p1x * t2x;
		pr_s1[4] <= p1y * t2y;
		pr_s1[5] <= t1x * p2x;
		pr_s1[6] <= t1y * p2y;
		pr_s1[7] <= p1x * p2x;
		pr_s1[8] <= p1y * p2y;
	end

	// s2: dot products, rounded half away from zero
	logic signed [DTW-1:0] dsum [4];
	logic signed [DTW-1:0] drnd [4];
	logic signed [SW-1:0]  sm_s2 [4];   // S11, S12, S21, S22

	always_comb begin
		dsum[0] = pr_s1[0] + pr_s1[1] + pr_s1[2];
		dsum[1] = pr_s1[3] + pr_s1[4];
		dsum[2] = pr_s1[5] + pr_s1[6];
		dsum[3] = pr_s1[7] + pr_s1[8];
		for (int i = 0; i < 4; i++) begin
			// negative values take half minus one, then an arithmetic shift
			drnd[i] = (dsum[i] + (dsum[i][DTW-1] ? HF_D - DTW'(1) : HF_D)) >>> F;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			sm_s2[i] <= drnd[i][SW-1:0];
		end
	end

	// s3: squares and cross products of S
	logic signed [2*SW-1:0] ps_s3 [N_OUT];

	always_ff @(posedge clk) begin
		ps_s3[0] <= sm_s2[0] * sm_s2[0];
		ps_s3[1] <= sm_s2[1] * sm_s2[1];
		ps_s3[2] <= sm_s2[2] * sm_s2[2];
		ps_s3[3] <= sm_s2[3] * sm_s2[3];
		ps_s3[4] <= sm_s2[0] * sm_s2[1];
		ps_s3[5] <= sm_s2[3] * sm_s2[2];
		ps_s3[6] <= sm_s2[0] * sm_s2[2];
		ps_s3[7] <= sm_s2[3] * sm_s2[1];
		ps_s3[8] <= sm_s2[0] * sm_s2[3];
		ps_s3[9] <= sm_s2[1] * sm_s2[2];
	end

	// s4: Mueller entry sums
	logic signed [CW-1:0] cm_s4 [N_OUT];

	always_ff @(posedge clk) begin
		cm_s4[0] <= ps_s3[0] + ps_s3[1] + ps_s3[2] + ps_s3[3];
		cm_s4[1] <= ps_s3[0] - ps_s3[1] + ps_s3[2] - ps_s3[3];
		cm_s4[2] <= ps_s3[4] + ps_s3[5];
		cm_s4[3] <= ps_s3[0] + ps_s3[1] - ps_s3[2] - ps_s3[3];
		cm_s4[4] <= ps_s3[0] - ps_s3[1] - ps_s3[2] + ps_s3[3];
		cm_s4[5] <= ps_s3[4] - ps_s3[5];
		cm_s4[6] <= ps_s3[6] + ps_s3[7];
		cm_s4[7] <= ps_s3[6] - ps_s3[7];
		cm_s4[8] <= ps_s3[8] + ps_s3[9];
		cm_s4[9] <= ps_s3[8] - ps_s3[9];
	end

	// s5: sign and rounded magnitude; the half entries drop one more bit
	logic [CW-1:0]    hh [N_OUT];
	logic [CW-1:0]    ab [N_OUT];
	logic [CW-1:0]    sh [N_OUT];
	logic [MW-1:0]    mag_s5 [N_OUT];
	logic [N_OUT-1:0] neg_s5, neg_s6, neg_s7, neg_s8;

	always_comb begin
		for (int i = 0; i < N_OUT; i++) begin
			hh[i] = HALF_ENTRY[i] ? (CW'(1) << F) : (CW'(1) << (F-1));
			ab[i] = cm_s4[i][CW-1] ? hh[i] - cm_s4[i] : cm_s4[i] + hh[i];
			sh[i] = HALF_ENTRY[i] ? (ab[i] >> (F+1)) : (ab[i] >> F);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N_OUT; i++) begin
			mag_s5[i] <= sh[i][MW-1:0];
			neg_s5[i] <= cm_s4[i][CW-1];
		end
	end

	// s6..s8: opacity gain, back to Q.16, then 3*pi/8
	logic [PW-1:0] pg_s6 [N_OUT];
	logic [QW-1:0] q_s7  [N_OUT];
	logic [GW-1:0] g_s8  [N_OUT];

	always_ff @(posedge clk) begin
		neg_s6 <= neg_s5;
		neg_s7 <= neg_s6;
		neg_s8 <= neg_s7;
		for (int i = 0; i < N_OUT; i++) begin
			pg_s6[i] <= mag_s5[i] * opac_q;
			q_s7[i]  <= QW'(({1'b0, pg_s6[i]} + H_OP) >> F);
			g_s8[i]  <= q_s7[i] * GAIN_Q24;
		end
	end

	// s9: round, sign, saturate into the result registers
	logic [SATW-1:0]      uu  [N_OUT];
	logic [SATW-1:0]      nu  [N_OUT];
	logic [OUT_WIDTH-1:0] sat [N_OUT];
	logic [OUT_WIDTH-1:0] res_s9 [N_OUT];

	always_comb begin
		for (int i = 0; i < N_OUT; i++) begin
			uu[i] = SATW'(({1'b0, g_s8[i]} + H_GN) >> 24);
			nu[i] = SATW'(0) - uu[i];
			if (neg_s8[i]) begin
				sat[i] = (uu[i] > LIM_N) ? LIM_N[OUT_WIDTH-1:0] : nu[i][OUT_WIDTH-1:0];
			end else begin
				sat[i] = (uu[i] > MAX_P) ? MAX_P[OUT_WIDTH-1:0] : uu[i][OUT_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s8) begin
			res_s9 <= sat;
		end
	end

	assign row0_col0 = res_s9[0];
	assign row0_col1 = res_s9[1];
	assign row0_col2 = res_s9[2];
	assign row1_col0 = res_s9[3];
	assign row1_col1 = res_s9[4];
	assign row1_col2 = res_s9[5];
	assign row2_col0 = res_s9[6];
	assign row2_col1 = res_s9[7];
	assign row2_col2 = res_s9[8];
	assign row3_col3 = res_s9[9];

endmodule

### sv/rpm_axes.sv
// ----------------------------------------------------------------------------
// rpm_axes
// Pipelined theta/phi axis generator for one direction vector.
// ----------------------------------------------------------------------------
module rpm_axes #(
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic signed [DW-1:0] dir_x,
	input  logic signed [DW-1:0] dir_y,
	input  logic signed [DW-1:0] dir_z,
	output logic                 out_vld,
	output logic signed [DW-1:0] t_x,
	output logic signed [DW-1:0] t_y,
	output logic signed [DW-1:0] t_z,
	output logic signed [DW-1:0] p_x,
	output logic signed [DW-1:0] p_y
);

	localparam int F    = DW - 2;
	localparam int RW   = F + 1;
	localparam int REMW = RW + 3;

	// stage map
	localparam int S_LD  = 0;
	localparam int S_SQ  = 1;
	localparam int S_RAD = 2;
	localparam int S_RT  = 3;
	localparam int S_DV  = S_RT + RW;
	localparam int S_MUL = S_DV + RW;
	localparam int S_RND = S_MUL + 1;
	localparam int NST   = S_RND + 1;

	localparam logic [RW-1:0]   ONE_R  = RW'(1) << F;
	localparam logic [2*RW-1:0] ONE2   = (2*RW)'(1) << (2*F);
	localparam logic [2*RW-1:0] HALF_P = (2*RW)'(1) << (F-1);

	typedef struct packed {
		logic              sx, sy, sz;
		logic [RW-1:0]     ax, ay, az;
		logic [2*RW-1:0]   rad_t, rad_p;
		logic [REMW-1:0]   rem_t, rem_p;
		logic [RW-1:0]     root_t, root_p;
		logic [RW-1:0]     dr_x, dr_y, nl_x, nl_y, q_x, q_y;
		logic              scp, ssp;
		logic [RW-1:0]     cpm, spm;
		logic [2*RW-1:0]   pm_x, pm_y;
		logic signed [DW-1:0] t_x, t_y, t_z, p_x, p_y;
	} ax_stage_t;

	ax_stage_t        pipe_s [NST];
	logic [NST-1:0]   vld_s;

	// magnitude of a component, clamped to one
	function automatic logic [RW-1:0] sat_mag(input logic signed [DW-1:0] x);
		logic [DW:0] m;
		m = x[DW-1] ? ((DW+1)'(0) - {x[DW-1], x}) : {1'b0, x};
		return (m > (DW+1)'(ONE_R)) ? ONE_R : m[RW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NST-2:0], in_vld};
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_st
		if (k == S_LD) begin : g_ld
			ax_stage_t nxt;
			always_comb begin
				nxt    = '0;
				nxt.sx = dir_x[DW-1];
				nxt.sy = dir_y[DW-1];
				nxt.sz = dir_z[DW-1];
				nxt.ax = sat_mag(dir_x);
				nxt.ay = sat_mag(dir_y);
				nxt.az = sat_mag(dir_z);
			end
			always_ff @(posedge clk) begin
				pipe_s[k] <= nxt;
			end
		end else if (k == S_SQ) begin : g_sq
			ax_stage_t nxt;
			always_comb begin
				nxt       = pipe_s[k-1];
				nxt.rad_t = pipe_s[k-1].az * pipe_s[k-1].az;
				nxt.rad_p = pipe_s[k-1].ax * pipe_s[k-1].ax
				          + pipe_s[k-1].ay * pipe_s[k-1].ay;
			end
			always_ff @(posedge clk) begin
				pipe_s[k] <= nxt;
			end
		end else if (k == S_RAD) begin : g_rad
			ax_stage_t nxt;
			always_comb begin
				nxt        = pipe_s[k-1];
				// sin theta is zero once nz^2 reaches one
				nxt.rad_t  = (pipe_s[k-1].rad_t >= ONE2) ? '0
				           : ONE2 - pipe_s[k-1].rad_t;
				nxt.rem_t  = '0;
				nxt.rem_p  = '0;
				nxt.root_t = '0;
				nxt.root_p = '0;
				// numerator |n|*2^F: high part seeds the remainder
				nxt.dr_x   = pipe_s[k-1].ax >> 1;
				nxt.dr_y   = pipe_s[k-1].ay >> 1;
				nxt.nl_x   = {pipe_s[k-1].ax[0], {F{1'b0}}};
				nxt.nl_y   = {pipe_s[k-1].ay[0], {F{1'b0}}};
				nxt.q_x    = '0;
				nxt.q_y    = '0;
			end
			always_ff @(posedge clk) begin
				pipe_s[k] <= nxt;
			end
		end else if (k < S_DV) begin : g_rt
			// one root bit per stage, both square roots side by side
			logic [REMW-1:0] cat_t, cat_p, trl_t, trl_p;
			logic            ge_t, ge_p;
			ax_stage_t       nxt;
			assign cat_t = {pipe_s[k-1].rem_t[REMW-3:0], pipe_s[k-1].rad_t[2*RW-1 -: 2]};
			assign cat_p = {pipe_s[k-1].rem_p[REMW-3:0], pipe_s[k-1].rad_p[2*RW-1 -: 2]};
			assign trl_t = {1'b0, pipe_s[k-1].root_t, 2'b01};
			assign trl_p = {1'b0, pipe_s[k-1].root_p, 2'b01};
			assign ge_t  = cat_t >= trl_t;
			assign ge_p  = cat_p >= trl_p;
			always_comb begin
				nxt        = pipe_s[k-1];
				nxt.rad_t  = pipe_s[k-1].rad_t << 2;
				nxt.rad_p  = pipe_s[k-1].rad_p << 2;
				nxt.rem_t  = ge_t ? cat_t - trl_t : cat_t;
				nxt.rem_p  = ge_p ? cat_p - trl_p : cat_p;
				nxt.root_t = {pipe_s[k-1].root_t[RW-2:0], ge_t};
				nxt.root_p = {pipe_s[k-1].root_p[RW-2:0], ge_p};
			end
			always_ff @(posedge clk) begin
				pipe_s[k] <= nxt;
			end
		end else if (k < S_MUL) begin : g_dv
			// restoring divide by the planar length, one quotient bit per stage
			logic [RW:0] dc_x, dc_y, dd;
			logic        g_x, g_y;
			ax_stage_t   nxt;
			assign dd   = {1'b0, pipe_s[k-1].root_p};
			assign dc_x = {pipe_s[k-1].dr_x, pipe_s[k-1].nl_x[RW-1]};
			assign dc_y = {pipe_s[k-1].dr_y, pipe_s[k-1].nl_y[RW-1]};
			assign g_x  = dc_x >= dd;
			assign g_y  = dc_y >= dd;
			always_comb begin
				nxt      = pipe_s[k-1];
				nxt.dr_x = g_x ? RW'(dc_x - dd) : dc_x[RW-1:0];
				nxt.dr_y = g_y ? RW'(dc_y - dd) : dc_y[RW-1:0];
				nxt.nl_x = pipe_s[k-1].nl_x << 1;
				nxt.nl_y = pipe_s[k-1].nl_y << 1;
				nxt.q_x  = {pipe_s[k-1].q_x[RW-2:0], g_x};
				nxt.q_y  = {pipe_s[k-1].q_y[RW-2:0], g_y};
			end
			always_ff @(posedge clk) begin
				pipe_s[k] <= nxt;
			end
		end else if (k == S_MUL) begin : g_mul
			// zero planar length: phi axis defaults to cos 1, sin 0
			logic          rz;
			logic [RW-1:0] cpm_w, spm_w;
			ax_stage_t     nxt;
			assign rz    = (pipe_s[k-1].root_p == '0);
			assign cpm_w = rz ? ONE_R : pipe_s[k-1].q_x;
			assign spm_w = rz ? '0 : pipe_s[k-1].q_y;
			always_comb begin
				nxt      = pipe_s[k-1];
				nxt.cpm  = cpm_w;
				nxt.spm  = spm_w;
				nxt.scp  = pipe_s[k-1].sx & ~rz;
				nxt.ssp  = pipe_s[k-1].sy & ~rz;
				nxt.pm_x = pipe_s[k-1].az * cpm_w;
				nxt.pm_y = pipe_s[k-1].az * spm_w;
			end
			always_ff @(posedge clk) begin
				pipe_s[k] <= nxt;
			end
		end else begin : g_rnd
			logic [RW-1:0] m_x, m_y;
			ax_stage_t     nxt;
			assign m_x = RW'((pipe_s[k-1].pm_x + HALF_P) >> F);
			assign m_y = RW'((pipe_s[k-1].pm_y + HALF_P) >> F);
			always_comb begin
				nxt     = pipe_s[k-1];
				nxt.t_x = (pipe_s[k-1].sz ^ pipe_s[k-1].scp) ?
				          -$signed({1'b0, m_x}) : $signed({1'b0, m_x});
				nxt.t_y = (pipe_s[k-1].sz ^ pipe_s[k-1].ssp) ?
				          -$signed({1'b0, m_y}) : $signed({1'b0, m_y});
				nxt.t_z = -$signed({1'b0, pipe_s[k-1].root_t});
				nxt.p_x = pipe_s[k-1].ssp ? $signed({1'b0, pipe_s[k-1].spm})
				          : -$signed({1'b0, pipe_s[k-1].spm});
				nxt.p_y = pipe_s[k-1].scp ? -$signed({1'b0, pipe_s[k-1].cpm})
				          : $signed({1'b0, pipe_s[k-1].cpm});
			end
			always_ff @(posedge clk) begin
				pipe_s[k] <= nxt;
			end
		end
	end

	assign out_vld = vld_s[NST-1];
	assign t_x     = pipe_s[NST-1].t_x;
	assign t_y     = pipe_s[NST-1].t_y;
	assign t_z     = pipe_s[NST-1].t_z;
	assign p_x     = pipe_s[NST-1].p_x;
	assign p_y     = pipe_s[NST-1].p_y;

endmodule

### sv/rpm_checker.sv
// ----------------------------------------------------------------------------
// rpm_checker
// Port-level checks for the Rayleigh phase matrix core.
// ----------------------------------------------------------------------------
module rpm_checker #(
	parameter int LAT = 44
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic pready
);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_fwd: assert property (@(posedge clk) disable iff (!arst_n) start |-> ##LAT done)
		else $error("transaction result missing");

	a_back: assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(start, LAT))
		else $error("result without transaction");

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !done)
		else $error("result right after reset");

endmodule

bind rayleigh_phase_matrix_core rpm_checker #(.LAT(LATENCY)) u_rpm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .pready(pready)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rayleigh_phase_matrix_core: drives direction pairs
// with random gaps, predicts all ten Mueller entries in fixed point and
// compares every done strobe against the oldest prediction. The opacity
// register is swept through its extremes between phases, with readback.
// ----------------------------------------------------------------------------
module testbench;
	import rpm_pkg::*;

	localparam int DW      = 16;
	localparam int OW      = 32;
	localparam int FR      = DW - 2;
	localparam int LATENCY = 2 * DW + 12;

	typedef logic [N_OUT-1:0][OW-1:0] mueller_t;
	typedef logic signed [DW-1:0] dir_t;

	// scoreboard: fixed-point Mueller predictor plus pending-result store
	class mueller_scoreboard;
		logic [31:0] opacity;
		mueller_t    pending[$];
		int          errors;
		int          matched;

		function new();
			opacity = OPAC_RESET;
			errors  = 0;
			matched = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		// round half away from zero, shift right by sh
		function longint rnd_sh(longint v, int sh);
			longint h;
			h = 64'sd1 <<< (sh - 1);
			if (v < 0)
				return -((-v + h) >>> sh);
			return (v + h) >>> sh;
		endfunction

		function longint isqrt(longint v);
			longint res, b;
			res = 0;
			b   = 64'sd1 <<< 62;
			while (b > v) b = b >>> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >>> 1) + b;
				end else begin
					res = res >>> 1;
				end
				b = b >>> 2;
			end
			return res;
		endfunction

		// components beyond +-1 are clamped
		function longint clamp_dir(dir_t raw);
			longint s;
			s = raw;
			if (s > (64'sd1 <<< FR)) s = 64'sd1 <<< FR;
			if (s < -(64'sd1 <<< FR)) s = -(64'sd1 <<< FR);
			return s;
		endfunction

		// theta and phi polarization axes of one direction
		function void axes(input longint nx, ny, nz, output longint t[3], output longint p[3]);
			longint one, st, r, cp, sp;
			one = 64'sd1 <<< FR;
			st  = (nz * nz >= one * one) ? 0 : isqrt(one * one - nz * nz);
			r   = isqrt(nx * nx + ny * ny);
			if (r == 0) begin
				cp = one;
				sp = 0;
			end else begin
				cp = (nx * one) / r;
				sp = (ny * one) / r;
			end
			t[0] = rnd_sh(nz * cp, FR);
			t[1] = rnd_sh(nz * sp, FR);
			t[2] = -st;
			p[0] = -sp;
			p[1] = cp;
			p[2] = 0;
		endfunction

		function longint dot(longint a[3], longint b[3]);
			return rnd_sh(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], FR);
		endfunction

		// gain 3*pi/8 * opacity, then saturate to the output width
		function logic [OW-1:0] apply_gain(longint e);
			longint unsigned m, q, u;
			longint s, maxv;
			maxv = (64'sd1 <<< (OW - 1)) - 1;
			m = (e < 0) ? -e : e;
			q = (m * 64'(opacity) + (64'd1 << (FR - 1))) >> FR;
			u = (q * 64'(GAIN_Q24) + (64'd1 << 23)) >> 24;
			s = (e < 0) ? -longint'(u) : longint'(u);
			if (s > maxv) s = maxv;
			if (s < -maxv - 1) s = -maxv - 1;
			return s[OW-1:0];
		endfunction

		// accepted transaction: predict the ten entries and queue them
		function void note_pair(dir_t ix, iy, iz, ox, oy, oz);
			longint t1[3], p1[3], t2[3], p2[3];
			longint s11, s12, s21, s22, a, b, c, d;
			longint e[N_OUT];
			mueller_t m;
			axes(clamp_dir(ix), clamp_dir(iy), clamp_dir(iz), t1, p1);
			axes(clamp_dir(ox), clamp_dir(oy), clamp_dir(oz), t2, p2);
			s11 = dot(t1, t2);
			s12 = dot(p1, t2);
			s21 = dot(t1, p2);
			s22 = dot(p1, p2);
			a = s11 * s11; b = s12 * s12; c = s21 * s21; d = s22 * s22;
			e[0] = rnd_sh(a + b + c + d, FR + 1);
			e[1] = rnd_sh(a - b + c - d, FR + 1);
			e[2] = rnd_sh(s11 * s12 + s22 * s21, FR);
			e[3] = rnd_sh(a + b - c - d, FR + 1);
			e[4] = rnd_sh(a - b - c + d, FR + 1);
			e[5] = rnd_sh(s11 * s12 - s22 * s21, FR);
			e[6] = rnd_sh(s11 * s21 + s22 * s12, FR);
			e[7] = rnd_sh(s11 * s21 - s22 * s12, FR);
			e[8] = rnd_sh(s11 * s22 + s12 * s21, FR);
			e[9] = rnd_sh(s22 * s11 - s12 * s21, FR);
			for (int k = 0; k < N_OUT; k++)
				m[k] = apply_gain(e[k]);
			pending.push_back(m);
		endfunction

		task check_entries(mueller_t got);
			mueller_t want;
			if (pending.size() == 0) begin
				report("result strobe with no transaction outstanding");
				return;
			end
			want = pending.pop_front();
			matched++;
			for (int k = 0; k < N_OUT; k++)
				if (got[k] !== want[k])
					report($sformatf("entry %0d got %h expected %h", k, got[k], want[k]));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	dir_t in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
	dir_t out_dir_x = '0, out_dir_y = '0, out_dir_z = '0;
	logic done;
	logic signed [OW-1:0] row0_col0, row0_col1, row0_col2, row1_col0, row1_col1;
	logic signed [OW-1:0] row1_col2, row2_col0, row2_col1, row2_col2, row3_col3;

	mueller_scoreboard sb = new();
	int n_sent = 0;

	always #5 clk = ~clk;

	rayleigh_phase_matrix_core #(.DIR_WIDTH(DW), .OUT_WIDTH(OW)) dut (.*);

	// result monitor: done and entries are sampled before this edge's updates
	always @(posedge clk)
		if (arst_n && done)
			sb.check_entries({row3_col3, row2_col2, row2_col1, row2_col0, row1_col2,
				row1_col1, row1_col0, row0_col2, row0_col1, row0_col0});

	// watchdog
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	// APB write of the opacity register, followed by a readback
	task write_opacity(logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(REG_OPACITY) << 2;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.opacity = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== v)
			sb.report($sformatf("opacity readback %h expected %h", prdata, v));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// one transaction, after a random hold-off; start stays high when no gap
	task send_pair(dir_t ix, iy, iz, ox, oy, oz);
		int gap;
		gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		in_dir_x  <= ix;
		in_dir_y  <= iy;
		in_dir_z  <= iz;
		out_dir_x <= ox;
		out_dir_y <= oy;
		out_dir_z <= oz;
		do @(posedge clk); while (busy);
		sb.note_pair(ix, iy, iz, ox, oy, oz);
		n_sent++;
	endtask

	// wait for all outstanding transactions, then let the pipe drain
	task drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (sb.pending.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// random unit vector in Q1.14
	task unit_vec(output dir_t x, output dir_t y, output dir_t z);
		real cz, sz, ph;
		cz = 2.0 * $urandom_range(0, 1000000) / 1000000.0 - 1.0;
		sz = $sqrt(1.0 - cz * cz);
		ph = 6.283185307 * $urandom_range(0, 1000000) / 1000000.0;
		x = dir_t'($rtoi(sz * $cos(ph) * 16384.0));
		y = dir_t'($rtoi(sz * $sin(ph) * 16384.0));
		z = dir_t'($rtoi(cz * 16384.0));
	endtask

	// direction mix: mostly unit vectors, some with z at +-1, some raw noise
	task rand_dir(output dir_t x, output dir_t y, output dir_t z);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			unit_vec(x, y, z);
		end else if (sel < 8) begin
			x = (sel == 6) ? dir_t'(0) : dir_t'($urandom_range(0, 32768) - 16384);
			y = (sel == 6) ? dir_t'(0) : dir_t'(0);
			z = ($urandom_range(0, 1) != 0) ? dir_t'(16384) : dir_t'(-16384);
		end else begin
			x = dir_t'($urandom);
			y = dir_t'($urandom);
			z = dir_t'($urandom);
		end
	endtask

	initial begin
		dir_t ax, ay, az, bx, by, bz;
		logic [31:0] opac_sweep[5];
		opac_sweep = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
			32'h0003_0000, 32'h0000_0000};
		opac_sweep[4] = $urandom;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the opacity, then directed corner transactions
		psel  <= 1'b1;
		paddr <= 3'(REG_OPACITY) << 2;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== OPAC_RESET)
			sb.report($sformatf("opacity after reset %h", prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);

		send_pair(0, 0, 0, 0, 0, 0);                          // zero vectors
		send_pair(0, 0, 16384, 0, 0, 16384);                  // both on +z pole
		send_pair(0, 0, -16384, 0, 0, 16384);                 // opposite poles
		send_pair(16384, 0, 0, 0, 16384, 0);                  // x then y
		send_pair(-16384, 0, 0, 16384, 0, 0);                 // backscatter
		send_pair(0, -16384, 0, 0, 0, -16384);
		send_pair(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
		send_pair(16'sh4001, 0, 0, 16'shBFFF, 0, 0);          // just past +-1
		send_pair(16384, 16384, 16384, -16384, 16384, -16384); // not unit length
		send_pair(11585, 11585, 0, 11585, 0, 11585);          // 45 degrees
		send_pair(9459, 9459, 9459, -9459, 9459, -9459);
		send_pair(1, 0, 16383, 0, 1, -16383);                 // tiny planar length
		send_pair(-1, -1, 0, 1, -1, 0);
		send_pair(8192, -14189, 0, -8192, 0, 14189);
		send_pair(16'shFFFF, 16'h0001, 16'sh5555, 16'shAAAA, 16'sh7FFE, 16'sh0002);
		for (int i = 0; i < 6; i++) begin
			unit_vec(ax, ay, az);
			unit_vec(bx, by, bz);
			send_pair(ax, ay, az, bx, by, bz);
		end
		drain();

		// random phases, each under a different opacity
		for (int ph = 0; ph < 5; ph++) begin
			write_opacity(opac_sweep[ph]);
			@(posedge clk);
			for (int i = 0; i < 250; i++) begin
				rand_dir(ax, ay, az);
				rand_dir(bx, by, bz);
				send_pair(ax, ay, az, bx, by, bz);
			end
			drain();
		end

		$display("Sent %0d direction pairs over 6 opacity settings, %0d results checked",
			n_sent, sb.matched);
		$display("Covered poles, zero planar length, clamped and non-unit inputs, saturation");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
			$display("testbench failed");
		end
		$finish;
	end

endmodule
